>>> hdl/kmp_pkg.sv
// shared types, constants and helpers for the kmp stream matcher
`timescale 1ns / 1ps
package kmp_pkg;

  localparam int KMP_PATTERN_DEPTH = 16;
  localparam int KMP_COUNT_WIDTH   = 32;
  localparam int KMP_OUT_WIDTH     = 32;

  // utf-8 continuation bytes look like 10xxxxxx
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_TEXT   = 2'd2
  } kmp_func_t;

  typedef struct packed {
    kmp_func_t  func;
    logic [7:0] data_byte;
  } kmp_in_t;

  typedef struct packed {
    logic                     match_found;
    logic [KMP_OUT_WIDTH-1:0] shift_chars;
    logic [KMP_OUT_WIDTH-1:0] occurrence_count;
    logic                     status;
  } kmp_out_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic       clear;
    logic       append;
    logic       text;
    logic [7:0] data_byte;
  } kmp_cell_ctrl_t;

  // events for the counter unit
  typedef struct packed {
    logic clear;
    logic pat_char;
    logic text_char;
    logic match;
  } kmp_stat_ev_t;

  function automatic logic starts_char(input logic [7:0] b);
    starts_char = (b & CONT_MASK) != CONT_TAG;
  endfunction

endpackage

>>> hdl/kmp_stream_matcher.sv
// top level of the byte-stream kmp matcher
`timescale 1ns / 1ps
// Streaming exact-match engine for a byte pattern of up to PATTERN_DEPTH bytes. Send a clear
// item first, then the pattern one byte per append item, then text one byte per text item.
// Every item gives exactly one result item, in the cycle after it is taken; the block takes one
// item per cycle unless stalled, set by the single pass of the text byte through the cell row.
// Each cell holds one pattern byte and a bit saying that the pattern prefix ending in that
// cell matches the text so far; the bit moves one cell along per text byte, which finds every
// occurrence, overlapping ones included, just as a kmp failure walk does. A match reports the
// start offset in utf-8 characters (bytes that are not 10xxxxxx) and the saturating count of
// occurrences since clear. Appends after text has started, or past a full pattern, are
// refused with status 1 and change nothing. An empty pattern never matches. The output holds
// in a register while stalled and the input is stalled only while that register is full
// and not being taken.
module kmp_stream_matcher
  import kmp_pkg::*;
#(
  parameter int PATTERN_DEPTH = KMP_PATTERN_DEPTH,
  parameter int COUNT_WIDTH   = KMP_COUNT_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  kmp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output kmp_out_t out_data
);

  // pattern length needs to hold the depth itself
  localparam int LW = $clog2(PATTERN_DEPTH + 1);

  logic           accept;
  logic           is_clear, is_text, append_ok, refuse, start_char;
  logic [LW-1:0]  len_r, len_nxt;
  logic           started_r, started_nxt;
  logic           match;

  logic [PATTERN_DEPTH-1:0] load_vec, act_vec, last_vec, hit_vec;

  kmp_cell_ctrl_t cell_ctrl;
  kmp_stat_ev_t   stat_ev;

  logic [KMP_OUT_WIDTH-1:0] shift_chars, occ_count;

  logic     out_valid_r;
  kmp_out_t out_data_r;

  // input side waits only on a held, stalled result
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign start_char = starts_char(in_data.data_byte);

  // item decode
  always_comb begin
    is_clear  = 1'b0;
    is_text   = 1'b0;
    append_ok = 1'b0;
    refuse    = 1'b0;
    case (in_data.func)
      FUNC_CLEAR: begin
        is_clear = 1'b1;
      end
      FUNC_APPEND: begin
        refuse    = started_r || (len_r == LW'(PATTERN_DEPTH));
        append_ok = !refuse;
      end
      FUNC_TEXT: begin
        is_text = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_comb begin
    len_nxt     = len_r;
    started_nxt = started_r;
    if (is_clear) begin
      len_nxt     = '0;
      started_nxt = 1'b0;
    end else if (append_ok) begin
      len_nxt = len_r + 1'b1;
    end else if (is_text) begin
      started_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      started_r <= 1'b0;
    end else if (accept) begin
      len_r     <= len_nxt;
      started_r <= started_nxt;
    end
  end

  // broadcast to the cell row, gated by the handshake
  assign cell_ctrl.clear     = accept && is_clear;
  assign cell_ctrl.append    = accept && append_ok;
  assign cell_ctrl.text      = accept && is_text;
  assign cell_ctrl.data_byte = in_data.data_byte;

  genvar gi;
  generate
    for (gi = 0; gi < PATTERN_DEPTH; gi++) begin : g_cell
      logic prev_act;
      if (gi == 0) begin : g_head
        // the empty prefix always matches
        assign prev_act = 1'b1;
      end else begin : g_link
        assign prev_act = act_vec[gi-1];
      end

      assign load_vec[gi] = (len_r == LW'(gi));

      kmp_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (cell_ctrl),
        .load_sel (load_vec[gi]),
        .prev_act (prev_act),
        .act      (act_vec[gi]),
        .last     (last_vec[gi]),
        .hit      (hit_vec[gi])
      );
    end
  endgenerate

  // only the cell flagged last can report; no flag means empty pattern
  assign match = is_text && (|hit_vec);

  assign stat_ev.clear     = is_clear;
  assign stat_ev.pat_char  = append_ok && start_char;
  assign stat_ev.text_char = is_text && start_char;
  assign stat_ev.match     = match;

  kmp_stats #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .PCW         (LW)
  ) u_stats (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (accept),
    .ev               (stat_ev),
    .shift_chars      (shift_chars),
    .occurrence_count (occ_count)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r.match_found      <= match;
      out_data_r.shift_chars      <= shift_chars;
      out_data_r.occurrence_count <= occ_count;
      out_data_r.status           <= refuse ? STATUS_REFUSED : STATUS_OK;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // a held result must block the input side
  a_hold_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> in_stall)
    else $error("input taken while result held");

  // at most one cell marks the pattern end
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(last_vec))
    else $error("more than one last cell");

  // an empty pattern never reports a match
  a_empty_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_text && (len_r == '0)) |=> !out_data.match_found)
    else $error("match on empty pattern");

  // clear empties the pattern and the occurrence count
  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_clear) |=> ((len_r == '0) && (out_data.occurrence_count == '0)))
    else $error("clear left state behind");
`endif

endmodule

>>> hdl/kmp_cell.sv
// one cell of the matcher row: a pattern byte and its partial-match bit
`timescale 1ns / 1ps
module kmp_cell
  import kmp_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  kmp_cell_ctrl_t ctrl,
  input  logic           load_sel,
  input  logic           prev_act,
  output logic           act,
  output logic           last,
  output logic           hit
);

  logic [7:0] byte_r;
  logic       act_r;
  logic       act_nxt;
  logic       last_r;

  // prefix of length index+1 ends at the current text byte
  assign act_nxt = prev_act && (byte_r == ctrl.data_byte);
  assign hit     = last_r && act_nxt;
  assign act     = act_r;
  assign last    = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      act_r  <= 1'b0;
      last_r <= 1'b0;
    end else begin
      if (ctrl.append) begin
        last_r <= load_sel;
      end
      if (ctrl.text) begin
        act_r <= act_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.append && load_sel) begin
      byte_r <= ctrl.data_byte;
    end
  end

endmodule

>>> hdl/kmp_stats.sv
// character and occurrence counters, match offset
`timescale 1ns / 1ps
module kmp_stats
  import kmp_pkg::*;
#(
  parameter int COUNT_WIDTH = KMP_COUNT_WIDTH,
  parameter int PCW         = 5
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  kmp_stat_ev_t             ev,
  output logic [KMP_OUT_WIDTH-1:0] shift_chars,
  output logic [KMP_OUT_WIDTH-1:0] occurrence_count
);

  localparam int EXT_W = (COUNT_WIDTH > KMP_OUT_WIDTH) ? COUNT_WIDTH : KMP_OUT_WIDTH;

  logic [COUNT_WIDTH-1:0] text_cnt_r, text_cnt_nxt;
  logic [COUNT_WIDTH-1:0] match_tot_r, match_tot_nxt;
  logic [PCW-1:0]         pat_cnt_r, pat_cnt_nxt;
  logic [EXT_W-1:0]       text_ext, pat_ext, shift_ext, occ_ext;

  always_comb begin
    text_cnt_nxt  = text_cnt_r;
    match_tot_nxt = match_tot_r;
    pat_cnt_nxt   = pat_cnt_r;
    if (ev.clear) begin
      text_cnt_nxt  = '0;
      match_tot_nxt = '0;
      pat_cnt_nxt   = '0;
    end else begin
      if (ev.text_char && (text_cnt_r != '1)) begin
        text_cnt_nxt = text_cnt_r + 1'b1;
      end
      if (ev.match && (match_tot_r != '1)) begin
        match_tot_nxt = match_tot_r + 1'b1;
      end
      if (ev.pat_char) begin
        pat_cnt_nxt = pat_cnt_r + 1'b1;
      end
    end
  end

  // offset uses the text count including this byte
  always_comb begin
    text_ext  = EXT_W'(text_cnt_nxt);
    pat_ext   = EXT_W'(pat_cnt_r);
    occ_ext   = EXT_W'(match_tot_nxt);
    shift_ext = '0;
    if (ev.match && (text_ext >= pat_ext)) begin
      shift_ext = text_ext - pat_ext;
    end
  end

  assign shift_chars      = shift_ext[KMP_OUT_WIDTH-1:0];
  assign occurrence_count = occ_ext[KMP_OUT_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_cnt_r  <= '0;
      match_tot_r <= '0;
      pat_cnt_r   <= '0;
    end else if (en) begin
      text_cnt_r  <= text_cnt_nxt;
      match_tot_r <= match_tot_nxt;
      pat_cnt_r   <= pat_cnt_nxt;
    end
  end

endmodule
